>>> src/uyc_pkg.sv
// shared constants, types and fixed-point helpers for the uyvy to rgb converter
`default_nettype none

package uyc_pkg;

	// coefficients in signed q2.12, truncated toward zero
	localparam int FRAC_BITS = 12;
	localparam int COEF_W    = 15;
	localparam logic signed [COEF_W-1:0] COEF_Y  = 15'sd4767;
	localparam logic signed [COEF_W-1:0] COEF_RV = 15'sd6537;
	localparam logic signed [COEF_W-1:0] COEF_GV = 15'sd3330;
	localparam logic signed [COEF_W-1:0] COEF_GU = 15'sd1601;
	localparam logic signed [COEF_W-1:0] COEF_BU = 15'sd8265;

	localparam int PROD_W = 24;
	localparam int TERM_W = 10;
	localparam int SUM_W  = 12;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [8:0]        offs_t;

	localparam offs_t LUMA_OFFSET   = 9'sd16;
	localparam offs_t CHROMA_OFFSET = 9'sd128;
	localparam prod_t TRUNC_BIAS    = prod_t'((1 << FRAC_BITS) - 1);
	localparam sum_t  BYTE_MAX      = 12'sd255;

	// chroma terms shared by both pixels
	typedef struct packed {
		term_t tr;
		term_t tg;
		term_t tb;
	} chroma_terms_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// signed product over 4096, truncated toward zero
	function automatic term_t trunc_q12(input prod_t p);
		prod_t adj;
		adj = p[PROD_W-1] ? p + TRUNC_BIAS : p;
		return term_t'(adj >>> FRAC_BITS);
	endfunction

	function automatic logic [7:0] clamp_byte(input sum_t s);
		logic [7:0] res;
		if (s < 0) begin
			res = 8'd0;
		end else if (s > BYTE_MAX) begin
			res = 8'hFF;
		end else begin
			res = s[7:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> src/uyvy422_to_rgb24_converter.sv
// top level: uyvy 4:2:2 macropixel to two rgb24 pixels, bt.601 studio range
// three registered stages: multiply, truncate, add+clamp; the last drives the master side
// throughput: one word per cycle while m_tready is high
// each stage advances when empty or when the stage after it advances, so bubbles collapse
// reset: arst_n clears the stage valid bits at once; payload registers are not reset
`default_nettype none

module uyvy422_to_rgb24_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // chroma_blue, luma_first, chroma_red, luma_second
	input  wire logic        s_tlast,  // frame_end_in
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // red_first, green_first, blue_first,
	                                   // red_second, green_second, blue_second
	output logic             m_tlast   // frame_end_out
);

	// stage valid bits
	logic v_s1, v_s2, v_s3;
	// stage load enables
	logic en_s1, en_s2, en_s3;

	// frame end mark rides along with the pixel pair
	logic last_s1, last_s2, last_s3;

	uyc_pkg::term_t        luma0_s2;
	uyc_pkg::term_t        luma1_s2;
	uyc_pkg::chroma_terms_t terms_s2;
	uyc_pkg::rgb_t         pix0_s3;
	uyc_pkg::rgb_t         pix1_s3;

	// ready ripples back: a stage loads if it is empty or is handing its word on
	assign en_s3    = !v_s3 || m_tready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			last_s1 <= s_tlast;
		end
		if (en_s2) begin
			last_s2 <= last_s1;
		end
		if (en_s3) begin
			last_s3 <= last_s2;
		end
	end

	// two luma lanes, one per pixel of the pair
	uyc_luma_lane u_lane0 (
		.clk     (clk),
		.en_s1   (en_s1),
		.en_s2   (en_s2),
		.luma    (s_tdata[15:8]),
		.term_s2 (luma0_s2)
	);

	uyc_luma_lane u_lane1 (
		.clk     (clk),
		.en_s1   (en_s1),
		.en_s2   (en_s2),
		.luma    (s_tdata[31:24]),
		.term_s2 (luma1_s2)
	);

	// chroma terms are computed once and shared by both pixels
	uyc_chroma u_chroma (
		.clk         (clk),
		.en_s1       (en_s1),
		.en_s2       (en_s2),
		.chroma_blue (s_tdata[7:0]),
		.chroma_red  (s_tdata[23:16]),
		.terms_s2    (terms_s2)
	);

	uyc_merge u_merge (
		.clk     (clk),
		.en_s3   (en_s3),
		.luma0   (luma0_s2),
		.luma1   (luma1_s2),
		.terms   (terms_s2),
		.pix0_s3 (pix0_s3),
		.pix1_s3 (pix1_s3)
	);

	assign m_tvalid = v_s3;
	assign m_tlast  = last_s3;
	assign m_tdata  = {pix1_s3.b, pix1_s3.g, pix1_s3.r, pix0_s3.b, pix0_s3.g, pix0_s3.r};

endmodule

`default_nettype wire

>>> src/uyc_luma_lane.sv
// one luma lane: offset, scale by 1.164 and truncate
`default_nettype none

module uyc_luma_lane (
	input  wire logic           clk,
	input  wire logic           en_s1,
	input  wire logic           en_s2,
	input  wire logic [7:0]     luma,
	output uyc_pkg::term_t      term_s2
);

	uyc_pkg::offs_t d;
	uyc_pkg::prod_t prod_s1;

	assign d = $signed({1'b0, luma}) - uyc_pkg::LUMA_OFFSET;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= d * uyc_pkg::COEF_Y;
		end
		if (en_s2) begin
			term_s2 <= uyc_pkg::trunc_q12(prod_s1);
		end
	end

endmodule

`default_nettype wire

>>> src/uyc_chroma.sv
// chroma path: red, green and blue chroma terms shared by the pixel pair
`default_nettype none

module uyc_chroma (
	input  wire logic              clk,
	input  wire logic              en_s1,
	input  wire logic              en_s2,
	input  wire logic [7:0]        chroma_blue,
	input  wire logic [7:0]        chroma_red,
	output uyc_pkg::chroma_terms_t terms_s2
);

	uyc_pkg::offs_t u;
	uyc_pkg::offs_t v;
	uyc_pkg::prod_t rv_s1;
	uyc_pkg::prod_t gv_s1;
	uyc_pkg::prod_t gu_s1;
	uyc_pkg::prod_t bu_s1;
	uyc_pkg::prod_t gsum;

	assign u = $signed({1'b0, chroma_blue}) - uyc_pkg::CHROMA_OFFSET;
	assign v = $signed({1'b0, chroma_red}) - uyc_pkg::CHROMA_OFFSET;

	// green is truncated once, after both products are summed
	assign gsum = -gv_s1 - gu_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rv_s1 <= v * uyc_pkg::COEF_RV;
			gv_s1 <= v * uyc_pkg::COEF_GV;
			gu_s1 <= u * uyc_pkg::COEF_GU;
			bu_s1 <= u * uyc_pkg::COEF_BU;
		end
		if (en_s2) begin
			terms_s2.tr <= uyc_pkg::trunc_q12(rv_s1);
			terms_s2.tg <= uyc_pkg::trunc_q12(gsum);
			terms_s2.tb <= uyc_pkg::trunc_q12(bu_s1);
		end
	end

endmodule

`default_nettype wire

>>> src/uyc_merge.sv
// merge stage: add luma and chroma terms per channel and clamp to a byte
`default_nettype none

module uyc_merge (
	input  wire logic                  clk,
	input  wire logic                  en_s3,
	input  wire uyc_pkg::term_t        luma0,
	input  wire uyc_pkg::term_t        luma1,
	input  wire uyc_pkg::chroma_terms_t terms,
	output uyc_pkg::rgb_t              pix0_s3,
	output uyc_pkg::rgb_t              pix1_s3
);

	function automatic uyc_pkg::rgb_t mix(input uyc_pkg::term_t y,
			input uyc_pkg::chroma_terms_t t);
		uyc_pkg::rgb_t p;
		p.r = uyc_pkg::clamp_byte(uyc_pkg::sum_t'(y) + uyc_pkg::sum_t'(t.tr));
		p.g = uyc_pkg::clamp_byte(uyc_pkg::sum_t'(y) + uyc_pkg::sum_t'(t.tg));
		p.b = uyc_pkg::clamp_byte(uyc_pkg::sum_t'(y) + uyc_pkg::sum_t'(t.tb));
		return p;
	endfunction

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pix0_s3 <= mix(luma0, terms);
			pix1_s3 <= mix(luma1, terms);
		end
	end

endmodule

`default_nettype wire

>>> src/uyc_checker.sv
// port-level checker for the converter, bound to the top level
`default_nettype none

module uyc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast
);

	// words accepted but not yet delivered
	logic [2:0] pend_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in  = s_tvalid && s_tready;
	assign acc_out = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b0, acc_in} - {2'b0, acc_out};
		end
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// never more words in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more words in flight than stages");

	// no result word without a word accepted before it
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result word without matching input word");

	// input stalls only when every stage is full
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> pend_q == 3'd3 && m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule

bind uyvy422_to_rgb24_converter uyc_checker u_chk (.*);

`default_nettype wire

>>> test/uyvy422_to_rgb24_checker.sv
// checker for the uyvy to rgb24 converter: predicts each pixel pair and compares it on the master side
`default_nettype none

module uyvy422_to_rgb24_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,  // chroma_blue, luma_first, chroma_red, luma_second
	input  wire logic        s_tlast,  // frame_end_in
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,  // red_first, green_first, blue_first,
	                                   // red_second, green_second, blue_second
	input  wire logic        m_tlast,  // frame_end_out
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// bt.601 gains in q2.12
	localparam int LUMA_GAIN     = 4767;
	localparam int RED_CR_GAIN   = 6537;
	localparam int GREEN_CR_GAIN = 3330;
	localparam int GREEN_CB_GAIN = 1601;
	localparam int BLUE_CB_GAIN  = 8265;
	localparam int Q12_ONE       = 4096;
	localparam int REPORT_LIMIT  = 10;

	// chan[0] is red_first ... chan[5] is blue_second, same order as m_tdata
	typedef struct packed {
		logic            last;
		logic [5:0][7:0] chan;
	} pixel_pair_t;

	pixel_pair_t expected_pairs[$];
	int          pair_count;

	function automatic logic [7:0] saturate_byte(input int level);
		logic [7:0] res;
		if (level < 0) begin
			res = 8'd0;
		end else if (level > 255) begin
			res = 8'd255;
		end else begin
			res = level[7:0];
		end
		return res;
	endfunction

	// integer division in sv truncates toward zero, matching uyc_pkg::trunc_q12 in the design
	function automatic pixel_pair_t convert_macropixel(input logic [31:0] word, input logic last);
		pixel_pair_t res;
		int          cb, cr, luma0, luma1, red_term, green_term, blue_term;
		cb         = int'(word[7:0]) - 128;
		cr         = int'(word[23:16]) - 128;
		luma0      = ((int'(word[15:8]) - 16) * LUMA_GAIN) / Q12_ONE;
		luma1      = ((int'(word[31:24]) - 16) * LUMA_GAIN) / Q12_ONE;
		red_term   = (cr * RED_CR_GAIN) / Q12_ONE;
		green_term = (-(cr * GREEN_CR_GAIN) - (cb * GREEN_CB_GAIN)) / Q12_ONE;
		blue_term  = (cb * BLUE_CB_GAIN) / Q12_ONE;
		res.chan[0] = saturate_byte(luma0 + red_term);
		res.chan[1] = saturate_byte(luma0 + green_term);
		res.chan[2] = saturate_byte(luma0 + blue_term);
		res.chan[3] = saturate_byte(luma1 + red_term);
		res.chan[4] = saturate_byte(luma1 + green_term);
		res.chan[5] = saturate_byte(luma1 + blue_term);
		res.last    = last;
		return res;
	endfunction

	always @(posedge clk) begin
		pixel_pair_t got;
		pixel_pair_t want;
		int          bad;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_pairs.push_back(convert_macropixel(s_tdata, s_tlast));
			end
			if (m_tvalid && m_tready) begin
				got.chan = m_tdata;
				got.last = m_tlast;
				if (expected_pairs.size() == 0) begin
					if (mismatches < REPORT_LIMIT) begin
						$display("pair %0d: unexpected word %h last %b", pair_count, got.chan,
							got.last);
					end
					mismatches++;
				end else begin
					want = expected_pairs.pop_front();
					bad  = 0;
					for (int k = 0; k < 6; k++) begin
						if (got.chan[k] !== want.chan[k]) begin
							bad++;
						end
					end
					if (got.last !== want.last) begin
						bad++;
					end
					if (bad != 0) begin
						if (mismatches < REPORT_LIMIT) begin
							$display("pair %0d: expected %h last %b, got %h last %b", pair_count,
								want.chan, want.last, got.chan, got.last);
						end
						mismatches++;
					end
				end
				pair_count++;
			end
			outstanding = expected_pairs.size();
		end
	end

endmodule

`default_nettype wire

>>> test/tb_uyvy422_to_rgb24_converter.sv
// testbench top for the uyvy to rgb24 converter: stimulus, flow control and verdict
`default_nettype none

module tb_uyvy422_to_rgb24_converter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 950;
	localparam int IDLE_PCT     = 34;     // chance of an idle cycle on either side
	localparam int HOLD_CYCLES  = 80;     // long receiver hold-off, well past pipeline depth
	localparam int DRAIN_CYCLES = 8;      // pipeline is three stages deep
	localparam int CYCLE_LIMIT  = 400000; // cycle bound for the watchdog

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tready = 1'b0;
	wire logic        s_tready;
	wire logic        m_tvalid;
	wire logic [47:0] m_tdata;
	wire logic        m_tlast;

	int mismatches;
	int outstanding;
	int cycle_count;

	// no_idle: both sides run flat out; hold_off_req: receiver stalls for a long stretch
	bit no_idle;
	bit hold_off_req;

	uyvy422_to_rgb24_converter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	uyvy422_to_rgb24_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// pick one byte: mostly full range, some studio range, some corner values
	function automatic logic [7:0] pick_level(input bit is_chroma);
		logic [7:0] res;
		int         roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			res = 8'($urandom_range(0, 255));
		end else if (roll < 85) begin
			res = is_chroma ? 8'($urandom_range(16, 240)) : 8'($urandom_range(16, 235));
		end else begin
			case ($urandom_range(0, 11))
				0:       res = 8'd0;
				1:       res = 8'd1;
				2:       res = 8'd15;
				3:       res = 8'd16;
				4:       res = 8'd17;
				5:       res = 8'd127;
				6:       res = 8'd128;
				7:       res = 8'd129;
				8:       res = 8'd235;
				9:       res = 8'd236;
				10:      res = 8'd254;
				default: res = 8'd255;
			endcase
		end
		return res;
	endfunction

	// offer one macropixel word and hold it until the slave side takes it;
	// random idle cycles in front carry noise on tdata/tlast with tvalid low
	task automatic send_macropixel(input logic [7:0] cb, input logic [7:0] y0,
		input logic [7:0] cr, input logic [7:0] y1, input logic last);
		while (!(no_idle || hold_off_req) && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tlast  <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y1, cr, y0, cb};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// receiver: random back-pressure, none during the quiet stretch, one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// black and white at the studio limits
		send_macropixel(8'd128, 8'd16, 8'd128, 8'd235, 1'b0);
		// luma right at the top clamp edge
		send_macropixel(8'd128, 8'd235, 8'd128, 8'd236, 1'b0);
		// luma above the top and below the bottom of studio range
		send_macropixel(8'd128, 8'd237, 8'd128, 8'd15, 1'b0);
		// all-zero and all-one words
		send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		// chroma extremes: green far above and far below range
		send_macropixel(8'd0, 8'd128, 8'd0, 8'd128, 1'b0);
		send_macropixel(8'd255, 8'd128, 8'd255, 8'd128, 1'b0);
		// opposite chroma extremes with opposite luma extremes
		send_macropixel(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		send_macropixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
		// small negative and positive products, truncation toward zero
		send_macropixel(8'd127, 8'd17, 8'd127, 8'd17, 1'b0);
		send_macropixel(8'd129, 8'd17, 8'd129, 8'd17, 1'b0);
		send_macropixel(8'd128, 8'd16, 8'd129, 8'd16, 1'b0);
		send_macropixel(8'd128, 8'd16, 8'd127, 8'd16, 1'b0);
		send_macropixel(8'd127, 8'd16, 8'd128, 8'd16, 1'b0);
		send_macropixel(8'd129, 8'd16, 8'd128, 8'd16, 1'b0);
		// alternating bit patterns
		send_macropixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
		send_macropixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
		// saturated studio colors
		send_macropixel(8'd16, 8'd235, 8'd240, 8'd16, 1'b0);
		send_macropixel(8'd240, 8'd16, 8'd16, 8'd235, 1'b1);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_idle = (i >= 200 && i < 400);
			if (i == 600) begin
				hold_off_req = 1'b1;
			end
			send_macropixel(pick_level(1'b1), pick_level(1'b0), pick_level(1'b1),
				pick_level(1'b0), ($urandom_range(0, 15) == 0));
		end
		s_tvalid <= 1'b0;

		// drain, then keep watching for stray words
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
